### rtl/version_string_parse_compare_core_assert.svh
// Assertion macros shared by the version string parser RTL.
`ifndef VERSION_STRING_PARSE_COMPARE_CORE_ASSERT_SVH
`define VERSION_STRING_PARSE_COMPARE_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VSPC_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VSPC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/vspc_pkg.sv
// Package with the request and response types and constants of the version parser.
`default_nettype none
package vspc_pkg;

   localparam logic [29:0] VerLimit = 30'd999999999;

   localparam logic [7:0] CharLowerV = 8'h76;
   localparam logic [7:0] CharUpperV = 8'h56;
   localparam logic [7:0] CharDot    = 8'h2E;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;

   localparam logic [1:0] RelOlder = 2'd0;
   localparam logic [1:0] RelEqual = 2'd1;
   localparam logic [1:0] RelNewer = 2'd2;

   localparam logic [1:0] RegMajor = 2'd0;
   localparam logic [1:0] RegMinor = 2'd1;
   localparam logic [1:0] RegPatch = 2'd2;

   typedef struct packed {
      logic [7:0] in_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        parse_ok;
      logic [29:0] ver_major;
      logic [29:0] ver_minor;
      logic [29:0] ver_patch;
      logic [1:0]  relation;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/version_string_parse_compare_core.sv
// Streaming dotted version string parser with comparison against the installed version.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_ready  req_data (in_char, is_last)
//   rsp       out         rsp_valid/rsp_ready  rsp_data (parse_ok, major, minor, patch, relation)
//   csr       in          APB, pready high     current major, minor, patch at 0x0, 0x4, 0x8
//
// One request is taken per cycle while req_ready is high; the parse state updates at the accepting edge.
// A response for the last character passes through a parse stage, then the
// version compare stage that drives rsp_data.
// Requests stall only while both the parse stage and the response register are full
// and rsp_ready is low.
// Reset is synchronous and clears the parse state, the valid flags of both stages and the CSRs.
`default_nettype none
module version_string_parse_compare_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire vspc_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output vspc_pkg::rsp_type    rsp_data,
   input  wire                  csr_psel,
   input  wire                  csr_penable,
   input  wire                  csr_pwrite,
   input  wire  [3:0]           csr_paddr,
   input  wire  [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import vspc_pkg::*;

   localparam logic [2:0] PhLead   = 3'd0;
   localparam logic [2:0] PhPrefix = 3'd1;
   localparam logic [2:0] PhDigits = 3'd2;
   localparam logic [2:0] PhDot    = 3'd3;
   localparam logic [2:0] PhTrail  = 3'd4;
   localparam logic [2:0] PhBad    = 3'd5;

   typedef struct packed {
      logic        ok;
      logic [29:0] major;
      logic [29:0] minor;
      logic [29:0] patch;
   } res_type;

   logic [29:0] cur_major_ff, cur_minor_ff, cur_patch_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [29:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [29:0] part_major_ff, part_major_in;
   logic [29:0] part_minor_ff, part_minor_in;
   logic [29:0] part_patch_ff, part_patch_in;
   logic        res_valid_ff, res_valid_in;
   res_type     res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_accept, res_ready, csr_write;
   logic        is_space, is_digit, do_store, over;
   logic [33:0] prod;
   logic [29:0] sum30;
   logic [1:0]  relation;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         RegMajor: csr_prdata = {2'b00, cur_major_ff};
         RegMinor: csr_prdata = {2'b00, cur_minor_ff};
         RegPatch: csr_prdata = {2'b00, cur_patch_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   assign res_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !res_valid_ff || res_ready;
   assign req_accept = req_valid && req_ready;

   assign is_space = req_data.in_char inside {CharSpace, CharTab, CharCr, CharLf};
   assign is_digit = req_data.in_char inside {[CharZero:CharNine]};
   assign prod     = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + {30'd0, req_data.in_char[3:0]};
   assign over     = prod > {4'd0, VerLimit};
   assign sum30    = prod[29:0];

   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      part_major_in = part_major_ff;
      part_minor_in = part_minor_ff;
      part_patch_in = part_patch_ff;
      do_store      = 1'b0;
      res_in        = '0;

      case (phase_ff)
         PhLead: begin
            if (is_space) begin
               phase_in = PhLead;
            end else if (req_data.in_char == CharLowerV || req_data.in_char == CharUpperV) begin
               phase_in = PhPrefix;
            end else if (is_digit) begin
               phase_in = over ? PhBad : PhDigits;
               acc_in   = over ? acc_ff : sum30;
            end else begin
               phase_in = PhBad;
            end
         end
         PhPrefix, PhDot: begin
            if (is_digit) begin
               phase_in = over ? PhBad : PhDigits;
               acc_in   = over ? acc_ff : sum30;
            end else begin
               phase_in = PhBad;
            end
         end
         PhDigits: begin
            if (is_digit) begin
               phase_in = over ? PhBad : PhDigits;
               acc_in   = over ? acc_ff : sum30;
            end else if (req_data.in_char == CharDot) begin
               if (cnt_ff >= 2'd2) begin
                  phase_in = PhBad;
               end else begin
                  do_store = 1'b1;
                  phase_in = PhDot;
               end
            end else if (is_space) begin
               do_store = 1'b1;
               phase_in = PhTrail;
            end else begin
               phase_in = PhBad;
            end
         end
         PhTrail: begin
            if (!is_space) begin
               phase_in = PhBad;
            end
         end
         default: begin
            phase_in = PhBad;
         end
      endcase

      if (req_data.is_last && phase_in == PhDigits) begin
         do_store = 1'b1;
         phase_in = PhTrail;
      end

      if (do_store) begin
         case (cnt_ff)
            2'd0:    part_major_in = acc_in;
            2'd1:    part_minor_in = acc_in;
            default: part_patch_in = acc_in;
         endcase
         cnt_in = cnt_ff + 2'd1;
         acc_in = 30'd0;
      end

      if (req_data.is_last) begin
         res_in.ok = (phase_in == PhTrail);
         if (res_in.ok) begin
            res_in.major = part_major_in;
            res_in.minor = part_minor_in;
            res_in.patch = part_patch_in;
         end
         phase_in      = PhLead;
         acc_in        = 30'd0;
         cnt_in        = 2'd0;
         part_major_in = 30'd0;
         part_minor_in = 30'd0;
         part_patch_in = 30'd0;
      end
   end

   always_comb begin
      if (res_ff.major != cur_major_ff) begin
         relation = (res_ff.major < cur_major_ff) ? RelOlder : RelNewer;
      end else if (res_ff.minor != cur_minor_ff) begin
         relation = (res_ff.minor < cur_minor_ff) ? RelOlder : RelNewer;
      end else if (res_ff.patch != cur_patch_ff) begin
         relation = (res_ff.patch < cur_patch_ff) ? RelOlder : RelNewer;
      end else begin
         relation = RelEqual;
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in       = res_valid_ff;
         rsp_in.parse_ok    = res_ff.ok;
         rsp_in.ver_major   = res_ff.major;
         rsp_in.ver_minor   = res_ff.minor;
         rsp_in.ver_patch   = res_ff.patch;
         rsp_in.relation    = relation;
         res_valid_in       = 1'b0;
      end
      if (req_accept && req_data.is_last) begin
         res_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_major_ff  <= 30'd0;
         cur_minor_ff  <= 30'd0;
         cur_patch_ff  <= 30'd0;
         phase_ff      <= PhLead;
         acc_ff        <= 30'd0;
         cnt_ff        <= 2'd0;
         part_major_ff <= 30'd0;
         part_minor_ff <= 30'd0;
         part_patch_ff <= 30'd0;
         res_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_paddr[3:2])
               RegMajor: cur_major_ff <= csr_pwdata[29:0];
               RegMinor: cur_minor_ff <= csr_pwdata[29:0];
               RegPatch: cur_patch_ff <= csr_pwdata[29:0];
               default:  cur_major_ff <= cur_major_ff;
            endcase
         end
         if (req_accept) begin
            phase_ff      <= phase_in;
            acc_ff        <= acc_in;
            cnt_ff        <= cnt_in;
            part_major_ff <= part_major_in;
            part_minor_ff <= part_minor_in;
            part_patch_ff <= part_patch_in;
         end
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.is_last) begin
         res_ff <= res_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "version_string_parse_compare_core_assert.svh"

   `VSPC_ASSERT_SAME(a_invalid_zero, rsp_valid && !rsp_data.parse_ok,
      rsp_data.ver_major == 30'd0 && rsp_data.ver_minor == 30'd0 && rsp_data.ver_patch == 30'd0,
      "Invalid response carries a nonzero version.")
   `VSPC_ASSERT_SAME(a_acc_limit, 1'b1, acc_ff <= VerLimit,
      "Accumulator exceeds the component limit.")
   `VSPC_ASSERT_SAME(a_cnt_trail, cnt_ff == 2'd3, phase_ff == PhTrail || phase_ff == PhBad,
      "Third component stored outside trailing whitespace.")
   `VSPC_ASSERT_NEXT(a_clear_after_last, req_accept && req_data.is_last,
      phase_ff == PhLead && acc_ff == 30'd0 && cnt_ff == 2'd0,
      "Parse state not cleared after the last character.")

endmodule
`default_nettype wire

### tb/sv/tb_version_string_parse_compare_core.sv
// Self-checking testbench for the streaming version string parser and comparator.
module tb_version_string_parse_compare_core;
   import vspc_pkg::*;

   localparam int WatchLimit = 5000;
   localparam int LongStall = 400;
   localparam int SegmentBytes = 200;

   typedef enum logic [2:0] {
      ScanLead, ScanPrefix, ScanDigits, ScanDot, ScanTrail, ScanBad
   } scan_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   req_type     pending_chars[$];
   rsp_type     expected_versions[$];
   logic [7:0]  word_buf[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_epoch = 0;
   int seen_epoch = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int fail_count = 0;

   logic [29:0] installed_major = '0;
   logic [29:0] installed_minor = '0;
   logic [29:0] installed_patch = '0;

   scan_phase_type scan_phase = ScanLead;
   logic [29:0] part_acc = '0;
   logic [1:0]  part_count = '0;
   logic [29:0] part_major = '0;
   logic [29:0] part_minor = '0;
   logic [29:0] part_patch = '0;

   string directed_words[15] = '{
      "0", "v1.2.3", " V07.1\n", "999999999", "1000000000", "  ", "v", "1..2", "1.",
      ".1", "1.2.3.4", "1 2", "v 1", "1. 2", "1.x\015"
   };

   version_string_parse_compare_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic is_blank(input logic [7:0] c);
      return c == CharSpace || c == CharTab || c == CharCr || c == CharLf;
   endfunction

   function automatic logic is_numeral(input logic [7:0] c);
      return c >= CharZero && c <= CharNine;
   endfunction

   task automatic take_digit(input logic [7:0] c);
      logic [33:0] sum;
      sum = {4'd0, part_acc} * 34'd10 + {26'd0, c - CharZero};
      if (sum > {4'd0, VerLimit}) begin
         scan_phase = ScanBad;
      end else begin
         part_acc = sum[29:0];
         scan_phase = ScanDigits;
      end
   endtask

   task automatic close_part();
      case (part_count)
         2'd0: part_major = part_acc;
         2'd1: part_minor = part_acc;
         default: part_patch = part_acc;
      endcase
      part_count = part_count + 2'd1;
      part_acc = '0;
   endtask

   task automatic parse_char(input req_type item);
      logic [7:0] c;
      rsp_type res;
      c = item.in_char;
      case (scan_phase)
         ScanLead: begin
            if (is_blank(c)) begin
            end else if (c == CharLowerV || c == CharUpperV) begin
               scan_phase = ScanPrefix;
            end else if (is_numeral(c)) begin
               take_digit(c);
            end else begin
               scan_phase = ScanBad;
            end
         end
         ScanPrefix, ScanDot: begin
            if (is_numeral(c)) take_digit(c);
            else scan_phase = ScanBad;
         end
         ScanDigits: begin
            if (is_numeral(c)) begin
               take_digit(c);
            end else if (c == CharDot) begin
               if (part_count >= 2'd2) begin
                  scan_phase = ScanBad;
               end else begin
                  close_part();
                  scan_phase = ScanDot;
               end
            end else if (is_blank(c)) begin
               close_part();
               scan_phase = ScanTrail;
            end else begin
               scan_phase = ScanBad;
            end
         end
         ScanTrail: begin
            if (!is_blank(c)) scan_phase = ScanBad;
         end
         default: scan_phase = ScanBad;
      endcase
      if (item.is_last) begin
         if (scan_phase == ScanDigits) begin
            close_part();
            scan_phase = ScanTrail;
         end
         res = '0;
         res.parse_ok = (scan_phase == ScanTrail);
         if (res.parse_ok) begin
            res.ver_major = part_major;
            res.ver_minor = part_minor;
            res.ver_patch = part_patch;
         end
         if (res.ver_major != installed_major) begin
            res.relation = (res.ver_major < installed_major) ? RelOlder : RelNewer;
         end else if (res.ver_minor != installed_minor) begin
            res.relation = (res.ver_minor < installed_minor) ? RelOlder : RelNewer;
         end else if (res.ver_patch != installed_patch) begin
            res.relation = (res.ver_patch < installed_patch) ? RelOlder : RelNewer;
         end else begin
            res.relation = RelEqual;
         end
         expected_versions.insert(expected_versions.size(), res);
         scan_phase = ScanLead;
         part_acc = '0;
         part_count = '0;
         part_major = '0;
         part_minor = '0;
         part_patch = '0;
      end
   endtask

   function automatic void check_field(input string name, input logic [29:0] want,
                                       input logic [29:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_char(req_data);
         if (!req_valid || req_ready) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_chars.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_versions.size() == 0) begin
               $error("response with no request pending: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_versions.pop_front();
               check_field("parse_ok", 30'(want.parse_ok), 30'(rsp_data.parse_ok));
               check_field("ver_major", want.ver_major, rsp_data.ver_major);
               check_field("ver_minor", want.ver_minor, rsp_data.ver_minor);
               check_field("ver_patch", want.ver_patch, rsp_data.ver_patch);
               check_field("relation", 30'(want.relation), 30'(rsp_data.relation));
            end
         end
         if (stall_epoch != seen_epoch) begin
            seen_epoch <= stall_epoch;
            stall_left <= LongStall;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_installed(input logic [1:0] index, input logic [29:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {2'($urandom_range(3)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         RegMajor: installed_major = value;
         RegMinor: installed_minor = value;
         default: installed_patch = value;
      endcase
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) word_buf.insert(word_buf.size(), s[i]);
   endtask

   task automatic add_blank();
      case ($urandom_range(3))
         0: word_buf.insert(word_buf.size(), CharSpace);
         1: word_buf.insert(word_buf.size(), CharTab);
         2: word_buf.insert(word_buf.size(), CharCr);
         default: word_buf.insert(word_buf.size(), CharLf);
      endcase
   endtask

   task automatic queue_word();
      req_type item;
      int i;
      for (i = 0; i < word_buf.size(); i++) begin
         item.in_char = word_buf[i];
         item.is_last = (i == word_buf.size() - 1);
         pending_chars.insert(pending_chars.size(), item);
      end
      word_buf.delete();
   endtask

   function automatic int unsigned pick_part(input int slot);
      logic [29:0] cur;
      cur = (slot == 0) ? installed_major : (slot == 1) ? installed_minor : installed_patch;
      if (slot > 2) return $urandom_range(20);
      case ($urandom_range(9))
         0, 1, 2: return $urandom_range(20);
         3: return 32'(cur);
         4: return 32'(cur) + 1;
         5: return (cur == 0) ? 0 : 32'(cur) - 1;
         6: return 32'(VerLimit);
         7: return $urandom_range(999999999);
         8: return 32'(VerLimit) + 1 + $urandom_range(5000);
         default: return $urandom_range(99999);
      endcase
   endfunction

   task automatic build_word();
      int parts;
      int kind;
      int k;
      int pos;
      logic [7:0] noise;
      string marks;
      marks = "0123456789.vV \t";
      kind = $urandom_range(19);
      word_buf.delete();
      if (kind < 3) begin
         repeat ($urandom_range(6, 1)) begin
            word_buf.insert(word_buf.size(),
                            $urandom_range(1) ? 8'($urandom_range(255))
                                              : marks[$urandom_range(marks.len() - 1)]);
         end
      end else begin
         repeat (($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0) add_blank();
         case ($urandom_range(3))
            0: add_text("v");
            1: add_text("V");
            default: ;
         endcase
         parts = ($urandom_range(11) == 0) ? 4 : $urandom_range(3, 1);
         for (k = 0; k < parts; k++) begin
            if (k > 0) add_text(".");
            if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) add_text("0");
            add_text($sformatf("%0d", pick_part(k)));
         end
         repeat (($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0) add_blank();
         if (kind < 6) begin
            pos = $urandom_range(word_buf.size() - 1);
            noise = $urandom_range(1) ? 8'($urandom_range(255))
                                      : marks[$urandom_range(marks.len() - 1)];
            case ($urandom_range(2))
               0: word_buf[pos] = noise;
               1: word_buf.insert(pos, noise);
               default: begin
                  if (word_buf.size() > 1) word_buf.delete(pos);
                  else word_buf[pos] = noise;
               end
            endcase
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_valid || expected_versions.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   initial begin : stimulus
      int seg;
      int budget;
      int w;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      recv_idle_pct = 74;
      for (w = 0; w < 15; w++) begin
         add_text(directed_words[w]);
         queue_word();
      end
      add_text("1");
      word_buf.insert(word_buf.size(), 8'hFF);
      queue_word();
      word_buf.insert(word_buf.size(), 8'h00);
      queue_word();
      wait_drained();

      for (seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (seg)
            1: begin
               write_installed(RegMajor, 30'd1);
               write_installed(RegMinor, 30'd2);
               write_installed(RegPatch, 30'd3);
            end
            2: begin
               write_installed(RegMajor, VerLimit);
               write_installed(RegMinor, VerLimit);
               write_installed(RegPatch, VerLimit);
            end
            3: begin
               write_installed(RegMajor, 30'h3FFFFFFF);
               write_installed(RegMinor, 30'h3FFFFFFF);
               write_installed(RegPatch, 30'h3FFFFFFF);
            end
            4: begin
               write_installed(RegMajor, 30'($urandom_range(20)));
               write_installed(RegMinor, 30'($urandom_range(999999999)));
               write_installed(RegPatch, 30'($urandom_range(20)));
            end
            5: begin
               write_installed(RegMajor, 30'd0);
               write_installed(RegMinor, 30'd0);
               write_installed(RegPatch, 30'd0);
            end
            default: ;
         endcase
         budget = SegmentBytes;
         while (budget > 0) begin
            build_word();
            budget -= word_buf.size();
            queue_word();
         end
         if (seg == 0) stall_epoch++;
         wait_drained();
      end

      if (fail_count == 0 && expected_versions.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/vspc_pkg.sv
rtl/version_string_parse_compare_core.sv
tb/sv/tb_version_string_parse_compare_core.sv
